@@ hw/rtl/lsme_pkg.sv @@
`timescale 1ns / 1ps

package lsme_pkg;

	localparam int PIXEL_COUNT_BITS = 24;
	localparam int QUEUE_DEPTH      = 4;
	localparam int CFG_W            = 25;
	localparam int CHAN_W           = 8;
	localparam int STATUS_W         = 3;
	localparam int MIN_PIXELS       = 22;
	localparam int HDR_MAGIC_BYTES  = 4;
	localparam int HDR_BYTES        = 8;

	localparam logic [31:0] MAGIC_WORD = "STEG";

	typedef enum logic [STATUS_W-1:0] {
		ST_DATA   = 3'd0,
		ST_DONE   = 3'd1,
		ST_SMALL  = 3'd2,
		ST_MAGIC  = 3'd3,
		ST_LENGTH = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_MESSAGE = 2'd1,
		PH_IDLE    = 2'd2
	} phase_t;

	// One queue entry holds the results of one pixel. When two is set, the
	// first result is followed by a message-done result.
	typedef struct packed {
		logic [CHAN_W-1:0] data_byte;
		status_t           status;
		logic              two;
	} entry_t;

endpackage

@@ hw/rtl/lsme_if.sv @@
`timescale 1ns / 1ps

interface lsme_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [lsme_pkg::CHAN_W-1:0] red;
	logic [lsme_pkg::CHAN_W-1:0] green;
	logic [lsme_pkg::CHAN_W-1:0] blue;

	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

interface lsme_result_if;
	logic                         valid;
	logic                         ready;
	logic [lsme_pkg::CHAN_W-1:0]   byte_value;
	logic [lsme_pkg::STATUS_W-1:0] status;
	logic                         last;

	modport source(output valid, byte_value, status, last, input ready);
	modport sink(input valid, byte_value, status, last, output ready);
endinterface

@@ hw/rtl/lsme_front.sv @@
`timescale 1ns / 1ps

module lsme_front #(
	parameter int PIXEL_COUNT_BITS = lsme_pkg::PIXEL_COUNT_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lsme_pkg::CFG_W-1:0] cfg_wdata,
	lsme_pixel_if.sink                 pixel,
	input  logic                       queue_full,
	output logic                       push,
	output lsme_pkg::entry_t           push_entry
);

	localparam int CW = PIXEL_COUNT_BITS + 1;
	localparam int WW = (CW > lsme_pkg::CFG_W) ? CW : lsme_pkg::CFG_W;
	localparam int LW = (CW + 1 > 33) ? CW + 1 : 33;
	localparam logic [WW-1:0] COUNT_MAX = WW'(1) << PIXEL_COUNT_BITS;

	lsme_pkg::phase_t phase_q, phase_d;
	logic [7:0]    acc_q, acc_d, acc_w;
	logic [2:0]    pos_q, pos_d, pos_w;
	logic [3:0]    hdr_q, hdr_d, hdr_w;
	logic [31:0]   ml_q, ml_d, ml_sh;
	logic [CW-1:0] ps_q, ps_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-2:0] capacity_q, capacity_d;

	logic [WW-1:0] wext, weff;
	logic [CW+1:0] count3;
	logic [2:0]    bits;
	logic          got;
	logic [7:0]    done_byte;
	logic          accept, too_small, run, too_long, rearm_hit;
	logic [CW:0]   ps_inc;

	assign pixel.ready = !queue_full;
	assign accept      = pixel.valid && pixel.ready;
	assign bits        = {pixel.blue[0], pixel.green[0], pixel.red[0]};

	assign wext       = WW'(cfg_wdata);
	assign weff       = (wext > COUNT_MAX) ? COUNT_MAX : wext;
	assign count_d    = weff[CW-1:0];
	assign count3     = {2'b00, count_d} + {1'b0, count_d, 1'b0};
	assign capacity_d = count3[CW+1:3];

	assign too_small = (ps_q == '0) && (count_q < CW'(lsme_pkg::MIN_PIXELS))
		&& (phase_q != lsme_pkg::PH_IDLE);
	assign run       = (phase_q != lsme_pkg::PH_IDLE) && !too_small;
	assign ps_inc    = {1'b0, ps_q} + (CW+1)'(1);
	assign rearm_hit = ps_inc >= {1'b0, count_q};

	// Bits enter the byte from its most significant end; at most one byte
	// completes per pixel.
	always_comb begin
		acc_w     = acc_q;
		pos_w     = pos_q;
		got       = 1'b0;
		done_byte = '0;
		for (int c = 0; c < 3; c++) begin
			acc_w[pos_w] = acc_w[pos_w] | bits[c];
			if (pos_w == 3'd0) begin
				if (!got) begin
					done_byte = acc_w;
					got       = 1'b1;
				end
				acc_w = '0;
				pos_w = 3'd7;
			end else begin
				pos_w = pos_w - 3'd1;
			end
		end
	end

	assign hdr_w    = hdr_q + 4'd1;
	assign ml_sh    = {ml_q[23:0], done_byte};
	assign too_long = (LW'(ml_sh) + LW'(8)) > LW'(capacity_q);

	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		pos_d      = pos_q;
		hdr_d      = hdr_q;
		ml_d       = ml_q;
		ps_d       = ps_q;
		push       = 1'b0;
		push_entry = '{data_byte: '0, status: lsme_pkg::ST_DATA, two: 1'b0};
		if (cfg_we) begin
			phase_d = lsme_pkg::PH_HEADER;
			acc_d   = '0;
			pos_d   = 3'd7;
			hdr_d   = '0;
			ml_d    = '0;
			ps_d    = '0;
		end else if (accept) begin
			if (too_small) begin
				push              = 1'b1;
				push_entry.status = lsme_pkg::ST_SMALL;
				phase_d           = lsme_pkg::PH_IDLE;
			end
			if (run) begin
				acc_d = acc_w;
				pos_d = pos_w;
				if (got) begin
					unique case (phase_q)
						lsme_pkg::PH_HEADER: begin
							hdr_d = hdr_w;
							if (hdr_w == 4'(lsme_pkg::HDR_MAGIC_BYTES)) begin
								ml_d = '0;
								if (ml_sh != lsme_pkg::MAGIC_WORD) begin
									push              = 1'b1;
									push_entry.status = lsme_pkg::ST_MAGIC;
									phase_d           = lsme_pkg::PH_IDLE;
								end
							end else if (hdr_w >= 4'(lsme_pkg::HDR_BYTES)) begin
								ml_d = ml_sh;
								if (too_long) begin
									push              = 1'b1;
									push_entry.status = lsme_pkg::ST_LENGTH;
									phase_d           = lsme_pkg::PH_IDLE;
								end else if (ml_sh == '0) begin
									push              = 1'b1;
									push_entry.status = lsme_pkg::ST_DONE;
									phase_d           = lsme_pkg::PH_IDLE;
								end else begin
									phase_d = lsme_pkg::PH_MESSAGE;
								end
							end else begin
								ml_d = ml_sh;
							end
						end
						lsme_pkg::PH_MESSAGE: begin
							push                 = 1'b1;
							push_entry.data_byte = done_byte;
							push_entry.status    = lsme_pkg::ST_DATA;
							push_entry.two       = (ml_q == 32'd1);
							ml_d                 = ml_q - 32'd1;
							if (ml_q == 32'd1) begin
								phase_d = lsme_pkg::PH_IDLE;
							end
						end
						default: begin
							phase_d = phase_q;
						end
					endcase
				end
			end
			ps_d = ps_inc[CW-1:0];
			if (rearm_hit) begin
				phase_d = lsme_pkg::PH_HEADER;
				acc_d   = '0;
				pos_d   = 3'd7;
				hdr_d   = '0;
				ml_d    = '0;
				ps_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= lsme_pkg::PH_HEADER;
			acc_q      <= '0;
			pos_q      <= 3'd7;
			hdr_q      <= '0;
			ml_q       <= '0;
			ps_q       <= '0;
			count_q    <= '0;
			capacity_q <= '0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			pos_q   <= pos_d;
			hdr_q   <= hdr_d;
			ml_q    <= ml_d;
			ps_q    <= ps_d;
			if (cfg_we) begin
				count_q    <= count_d;
				capacity_q <= capacity_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_message_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lsme_pkg::PH_MESSAGE |-> hdr_q == 4'(lsme_pkg::HDR_BYTES))
		else $error("message phase entered before the full header");
	a_pixels_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		ps_q == '0 || ps_q < count_q)
		else $error("pixel counter passed the image size");
`endif

endmodule

@@ hw/rtl/lsme_queue.sv @@
`timescale 1ns / 1ps

module lsme_queue #(
	parameter int DEPTH = lsme_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lsme_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output lsme_pkg::entry_t pop_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	lsme_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [NW-1:0]    cnt_q;

	assign full      = cnt_q == NW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("write into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("read from an empty queue");
`endif

endmodule

@@ hw/rtl/lsme_back.sv @@
`timescale 1ns / 1ps

module lsme_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             not_empty,
	input  lsme_pkg::entry_t pop_entry,
	output logic             pop,
	lsme_result_if.source    result
);

	logic                          valid_q;
	logic                          pending_q;
	logic [lsme_pkg::CHAN_W-1:0]   byte_q;
	logic [lsme_pkg::STATUS_W-1:0] status_q;
	logic                          last_q;
	logic                          load;

	assign load = !valid_q || result.ready;
	assign pop  = load && !pending_q && not_empty;

	assign result.valid      = valid_q;
	assign result.byte_value = byte_q;
	assign result.status     = status_q;
	assign result.last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pending_q <= 1'b0;
		end else if (load) begin
			if (pending_q) begin
				valid_q   <= 1'b1;
				pending_q <= 1'b0;
			end else begin
				valid_q   <= not_empty;
				pending_q <= not_empty && pop_entry.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pending_q) begin
				byte_q   <= '0;
				status_q <= lsme_pkg::ST_DONE;
				last_q   <= 1'b1;
			end else begin
				byte_q   <= pop_entry.data_byte;
				status_q <= pop_entry.status;
				last_q   <= !pop_entry.two;
			end
		end
	end

`ifndef SYNTHESIS
	a_pending_shown: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> valid_q && !last_q)
		else $error("done result pending without its data byte on the output");
`endif

endmodule

@@ hw/rtl/lsb_stego_message_extractor.sv @@
// Channel  | Direction | Payload                      | Handshake
// pixel    | in        | red, green, blue (8 b each)  | valid / ready
// result   | out       | byte_value, status, last     | valid / ready
// cfg      | in        | cfg_wdata (pixel_count, 25 b)| cfg_we, no wait
//
// A pixel is accepted in every cycle while the result queue has room.
// A result passes the result queue, then the output register; one per cycle while ready.
// A pixel with a final data byte gives two results: that byte, then a message-done result.
// A stalled result output fills the four-entry result queue before the pixel input stalls.
// Reset is asynchronous and clears the header state, counters and queue.
`timescale 1ns / 1ps

module lsb_stego_message_extractor #(
	parameter int PIXEL_COUNT_BITS = lsme_pkg::PIXEL_COUNT_BITS,
	parameter int QUEUE_DEPTH      = lsme_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lsme_pkg::CFG_W-1:0] cfg_wdata,
	lsme_pixel_if.sink                 pixel,
	lsme_result_if.source              result
);

	logic             push, full, pop, not_empty;
	lsme_pkg::entry_t push_entry, pop_entry;

	lsme_front #(
		.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pixel      (pixel),
		.queue_full (full),
		.push       (push),
		.push_entry (push_entry)
	);

	lsme_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.pop_entry  (pop_entry)
	);

	lsme_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.pop_entry (pop_entry),
		.pop       (pop),
		.result    (result)
	);

endmodule
